// ----- rtl/c2d_pkg.sv -----
// c2d_pkg: shared types, opcodes and limits for the conv2d core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package c2d_pkg;
    localparam int MAX_WIDTH_DEF      = 64;
    localparam int MAX_CHANNELS_DEF   = 32;
    localparam int MAX_KERNELS_DEF    = 64;
    localparam int MAX_KERNEL_DIM_DEF = 3;
    localparam int MAX_HEIGHT         = 4095;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KHEIGHT = 3'd2;
    localparam logic [2:0] REG_KWIDTH  = 3'd3;
    localparam logic [2:0] REG_CHAN    = 3'd4;
    localparam logic [2:0] REG_KCOUNT  = 3'd5;

    // clamp a register value: zero means one, above the limit saturates
    function automatic logic [11:0] clamp_reg(input logic [11:0] v, input logic [11:0] hi);
        logic [11:0] r;
        begin
            r = v;
            if (v == 12'd0) r = 12'd1;
            else if (v > hi) r = hi;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/conv2d_multichannel_bias_core.sv -----
// conv2d_multichannel_bias_core: top level, sequencer, MAC unit and output stage.
// Depends on c2d_pkg and c2d_ram.
//
// Usage: load weights (opcode 1) and biases (opcode 2) on the s_ channel, then
// stream image elements (opcode 0) in raster order, channel fastest. Config
// registers are written through cfg_we/cfg_index/cfg_data while idle; any write to
// a defined register (index 0 to 5) restarts the image position counters.
// A load or a pixel that completes no window leaves the core idle. A pixel that
// completes a window starts a walk over the window with one shared MAC: for
// each kernel, KH*KW*C reads of the line and weight memories, one per cycle,
// then a drain of the MAC pipeline and a write to the output register.
// Results leave on m_ in order; m_last_of_position marks the last kernel of a
// position and m_last_of_frame the final result of an image. If the receiver
// stalls, the sequencer waits with the result held in the output register; no
// new item is taken until all results of the current one are delivered.
// Reset clears counters, control state and registers to width 64, height 64,
// kernel 3x3, one channel, one kernel. Memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_multichannel_bias_core #(
    parameter int MAX_WIDTH      = c2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS   = c2d_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_KERNELS    = c2d_pkg::MAX_KERNELS_DEF,
    parameter int MAX_KERNEL_DIM = c2d_pkg::MAX_KERNEL_DIM_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [11:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic signed [15:0] s_sample,
    input  wire logic [1:0]         s_tap_row,
    input  wire logic [1:0]         s_tap_col,
    input  wire logic [4:0]         s_in_channel,
    input  wire logic [5:0]         s_kernel_sel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [11:0]             m_out_row,
    output logic [5:0]              m_out_col,
    output logic [5:0]              m_kernel_num,
    output logic signed [15:0]      m_value,
    output logic                    m_saturated,
    output logic                    m_last_of_position,
    output logic                    m_last_of_frame
);
    localparam int ROW_WORDS  = MAX_WIDTH * MAX_CHANNELS;
    localparam int LINE_DEPTH = MAX_KERNEL_DIM * ROW_WORDS;
    localparam int W_DEPTH    = MAX_KERNEL_DIM * MAX_KERNEL_DIM * MAX_CHANNELS * MAX_KERNELS;
    localparam int LA = $clog2(LINE_DEPTH);
    localparam int WA = $clog2(W_DEPTH);
    localparam int BA = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
    localparam int KW_ = $clog2(MAX_KERNELS + 1);
    localparam int ACCW = 48;

    // configuration registers
    logic [6:0]  width_reg, height_dummy;
    logic [11:0] height_reg;
    logic [1:0]  kh_reg, kw_reg;
    logic [5:0]  chan_reg;
    logic [6:0]  kcount_reg;
    logic        cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index <= c2d_pkg::REG_KCOUNT);
    assign height_dummy = 7'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd64;
            height_reg <= 12'd64;
            kh_reg     <= 2'd3;
            kw_reg     <= 2'd3;
            chan_reg   <= 6'd1;
            kcount_reg <= 7'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                c2d_pkg::REG_WIDTH:   width_reg  <= cfg_data[6:0];
                c2d_pkg::REG_HEIGHT:  height_reg <= cfg_data;
                c2d_pkg::REG_KHEIGHT: kh_reg     <= cfg_data[1:0];
                c2d_pkg::REG_KWIDTH:  kw_reg     <= cfg_data[1:0];
                c2d_pkg::REG_CHAN:    chan_reg   <= cfg_data[5:0];
                c2d_pkg::REG_KCOUNT:  kcount_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective (clamped) sizes
    logic [11:0] w_eff, h_eff, kh_eff, kw_eff, c_eff, kc_eff;
    assign w_eff  = c2d_pkg::clamp_reg({5'd0, width_reg} | {5'd0, height_dummy},
                                       12'(MAX_WIDTH));
    assign h_eff  = c2d_pkg::clamp_reg(height_reg, 12'(c2d_pkg::MAX_HEIGHT));
    assign kh_eff = c2d_pkg::clamp_reg({10'd0, kh_reg}, 12'(MAX_KERNEL_DIM));
    assign kw_eff = c2d_pkg::clamp_reg({10'd0, kw_reg}, 12'(MAX_KERNEL_DIM));
    assign c_eff  = c2d_pkg::clamp_reg({6'd0, chan_reg}, 12'(MAX_CHANNELS));
    assign kc_eff = c2d_pkg::clamp_reg({5'd0, kcount_reg}, 12'(MAX_KERNELS));

    // position counters
    logic [11:0] row_reg, row_next;
    logic [XW-1:0] col_reg, col_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic [DW-1:0] slot_reg, slot_next;   // row_reg mod MAX_KERNEL_DIM

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_OUT} state_t;
    state_t state_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // window walk counters
    logic [KW_-1:0] k_reg;
    logic [DW-1:0]  ky_reg, kx_reg;
    logic [CW-1:0]  c_reg;
    logic [11:0]    orow_reg;
    logic [XW-1:0]  ocol_reg;
    logic [DW-1:0]  oslot_reg;   // line slot of window top row
    logic           fend_reg;
    logic           mac_v_reg, mac_v2_reg, mac_first_reg, mac_first2_reg;
    logic           walk_last;

    // memory ports
    logic          lwe, wwe, bwe;
    logic [LA-1:0] lwaddr, lraddr;
    logic [WA-1:0] wwaddr, wraddr;
    logic [BA-1:0] bwaddr, braddr;
    logic [15:0]   lrdata, wrdata, brdata;

    c2d_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
        .aclk(aclk), .we(lwe), .waddr(lwaddr), .wdata(s_sample),
        .raddr(lraddr), .rdata(lrdata));
    c2d_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight (
        .aclk(aclk), .we(wwe), .waddr(wwaddr), .wdata(s_sample),
        .raddr(wraddr), .rdata(wrdata));
    c2d_ram #(.WIDTH(16), .DEPTH(MAX_KERNELS)) u_bias (
        .aclk(aclk), .we(bwe), .waddr(bwaddr), .wdata(s_sample),
        .raddr(braddr), .rdata(brdata));

    // input-side counter wrap before use
    logic [11:0]   row_use;
    logic [XW-1:0] col_use;
    logic [CW-1:0] ch_use;
    logic [DW-1:0] slot_use;
    logic          pix, wload_ok, completes;
    always_comb begin
        row_use  = (row_reg >= h_eff) ? 12'd0 : row_reg;
        slot_use = (row_reg >= h_eff) ? '0 : slot_reg;
        col_use  = ({{(32-XW){1'b0}}, col_reg} >= 32'(w_eff)) ? '0 : col_reg;
        ch_use   = ({{(32-CW){1'b0}}, ch_reg} >= 32'(c_eff)) ? '0 : ch_reg;
        pix      = s_fire && (s_opcode == c2d_pkg::OP_PIXEL);
        wload_ok = (32'(s_tap_row) < MAX_KERNEL_DIM) && (32'(s_tap_col) < MAX_KERNEL_DIM)
                   && (32'(s_in_channel) < MAX_CHANNELS) && (32'(s_kernel_sel) < MAX_KERNELS);
        completes = (32'(ch_use) == 32'(c_eff) - 1) && (32'(row_use) + 1 >= 32'(kh_eff))
                    && (32'(col_use) + 1 >= 32'(kw_eff));
    end

    // write side of the memories
    always_comb begin
        lwe    = pix;
        lwaddr = LA'((32'(slot_use) * MAX_WIDTH + 32'(col_use)) * MAX_CHANNELS
                     + 32'(ch_use));
        wwe    = s_fire && (s_opcode == c2d_pkg::OP_WEIGHT) && wload_ok;
        wwaddr = WA'((((32'(s_tap_row) * MAX_KERNEL_DIM + 32'(s_tap_col)) * MAX_CHANNELS
                      + 32'(s_in_channel)) * MAX_KERNELS) + 32'(s_kernel_sel));
        bwe    = s_fire && (s_opcode == c2d_pkg::OP_BIAS) && (32'(s_kernel_sel) < MAX_KERNELS);
        bwaddr = BA'(s_kernel_sel);
    end

    // counter advance
    always_comb begin
        row_next  = row_use;
        col_next  = col_use;
        ch_next   = ch_use;
        slot_next = slot_use;
        if (32'(ch_use) + 1 >= 32'(c_eff)) begin
            ch_next = '0;
            if (32'(col_use) + 1 >= 32'(w_eff)) begin
                col_next = '0;
                if (row_use + 12'd1 >= h_eff) begin
                    row_next  = 12'd0;
                    slot_next = '0;
                end else begin
                    row_next  = row_use + 12'd1;
                    slot_next = (32'(slot_use) == MAX_KERNEL_DIM - 1) ? '0 : slot_use + 1'b1;
                end
            end else begin
                col_next = col_use + 1'b1;
            end
        end else begin
            ch_next = ch_use + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            row_reg  <= 12'd0;
            col_reg  <= '0;
            ch_reg   <= '0;
            slot_reg <= '0;
        end else if (pix) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            ch_reg   <= ch_next;
            slot_reg <= slot_next;
        end
    end

    // read addresses for the current walk step
    logic [DW-1:0] lslot;
    always_comb begin
        lslot = (32'(oslot_reg) + 32'(ky_reg) >= MAX_KERNEL_DIM)
                ? DW'(32'(oslot_reg) + 32'(ky_reg) - MAX_KERNEL_DIM)
                : DW'(32'(oslot_reg) + 32'(ky_reg));
        lraddr = LA'((32'(lslot) * MAX_WIDTH + 32'(ocol_reg) + 32'(kx_reg)) * MAX_CHANNELS
                     + 32'(c_reg));
        wraddr = WA'((((32'(ky_reg) * MAX_KERNEL_DIM + 32'(kx_reg)) * MAX_CHANNELS
                      + 32'(c_reg)) * MAX_KERNELS) + 32'(k_reg));
        braddr = BA'(k_reg);
        walk_last = (32'(c_reg) + 1 >= 32'(c_eff)) && (32'(kx_reg) + 1 >= 32'(kw_eff))
                    && (32'(ky_reg) + 1 >= 32'(kh_eff));
    end

    // MAC pipeline: read -> product register -> accumulate
    logic signed [31:0]     prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [15:0]     bias_hold_reg;
    logic signed [ACCW-1:0] acc_sum;
    always_comb begin
        acc_sum = mac_first2_reg
                  ? ($signed({{(ACCW-30){bias_hold_reg[15]}}, bias_hold_reg, 14'd0})
                     + ACCW'(prod_reg))
                  : (acc_reg + ACCW'(prod_reg));
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= $signed(lrdata) * $signed(wrdata);
        if (mac_first_reg) bias_hold_reg <= brdata;
        if (mac_v2_reg) acc_reg <= acc_sum;
    end

    // floor shift by 14 and saturation
    logic signed [ACCW-15:0] shifted;
    logic                    sat_hi, sat_lo;
    assign shifted = acc_reg[ACCW-1:14];
    assign sat_hi  = shifted > $signed((ACCW-14)'(32767));
    assign sat_lo  = shifted < -$signed((ACCW-14)'(32768));

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid        <= 1'b0;
            mac_v_reg      <= 1'b0;
            mac_v2_reg     <= 1'b0;
            mac_first_reg  <= 1'b0;
            mac_first2_reg <= 1'b0;
            k_reg <= '0; ky_reg <= '0; kx_reg <= '0; c_reg <= '0;
        end else begin
            mac_v2_reg     <= mac_v_reg;
            mac_first2_reg <= mac_first_reg;
            mac_v_reg      <= 1'b0;
            mac_first_reg  <= 1'b0;
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (pix && completes) begin
                        orow_reg  <= row_use + 12'd1 - kh_eff;
                        ocol_reg  <= XW'(32'(col_use) + 1 - 32'(kw_eff));
                        oslot_reg <= (32'(slot_use) + 1 >= 32'(kh_eff))
                                     ? DW'(32'(slot_use) + 1 - 32'(kh_eff))
                                     : DW'(32'(slot_use) + 1 + MAX_KERNEL_DIM - 32'(kh_eff));
                        fend_reg  <= (row_use == h_eff - 12'd1)
                                     && (32'(col_use) == 32'(w_eff) - 1);
                        k_reg <= '0; ky_reg <= '0; kx_reg <= '0; c_reg <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    mac_v_reg     <= 1'b1;
                    mac_first_reg <= (c_reg == '0) && (kx_reg == '0) && (ky_reg == '0);
                    if (walk_last) begin
                        state_reg <= ST_DRAIN;
                    end else if (32'(c_reg) + 1 < 32'(c_eff)) begin
                        c_reg <= c_reg + 1'b1;
                    end else begin
                        c_reg <= '0;
                        if (32'(kx_reg) + 1 < 32'(kw_eff)) begin
                            kx_reg <= kx_reg + 1'b1;
                        end else begin
                            kx_reg <= '0;
                            ky_reg <= ky_reg + 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    // wait until the last product has reached the accumulator and the output register is free
                    if (!mac_v_reg && !mac_v2_reg && !(m_valid && !m_ready)) begin
                        m_valid            <= 1'b1;
                        m_out_row          <= orow_reg;
                        m_out_col          <= 6'(ocol_reg);
                        m_kernel_num       <= 6'(k_reg);
                        m_value            <= sat_hi ? 16'sh7fff
                                              : (sat_lo ? 16'sh8000 : shifted[15:0]);
                        m_saturated        <= sat_hi || sat_lo;
                        m_last_of_position <= (32'(k_reg) + 1 >= 32'(kc_eff));
                        m_last_of_frame    <= fend_reg && (32'(k_reg) + 1 >= 32'(kc_eff));
                        state_reg          <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    ky_reg <= '0; kx_reg <= '0; c_reg <= '0;
                    if (32'(k_reg) + 1 >= 32'(kc_eff)) begin
                        if (!m_valid || m_ready) state_reg <= ST_IDLE;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted during window walk");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value) && $stable(m_kernel_num)))
        else $error("result changed while stalled");
    a_frame_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_frame) |-> m_last_of_position)
        else $error("frame end without position end");
endmodule
`default_nettype wire

// ----- rtl/c2d_ram.sv -----
// c2d_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
